@@ hw/rtl/dtwa_pkg.sv @@
// Shared types, codes, reset values and the step size table of the DDS tuning word adjuster.
package dtwa_pkg;

   // Number of step sizes the knob hardware offers, and the usable ceiling derived from it.
   localparam int NUM_STEP_SIZES = 8;
   localparam int TABLE_SIZE     = 10;
   localparam int LEVEL_CAP_A    = (NUM_STEP_SIZES > 8) ? 8 : NUM_STEP_SIZES;
   localparam int LEVEL_CAP_B    = (LEVEL_CAP_A > TABLE_SIZE) ? TABLE_SIZE : LEVEL_CAP_A;
   localparam int LEVEL_LIMIT    = (LEVEL_CAP_B < 1) ? 1 : LEVEL_CAP_B;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 4;
   localparam int LEVEL_W = 3;
   localparam int STEP_W  = 24;

   // Reset values of the configuration registers.
   localparam logic [WORD_W-1:0]  MAX_FREQ_RESET     = 32'd40000000;
   localparam logic [WORD_W-1:0]  MAX_TWORD_RESET    = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0]  CLOCK_CENTER_RESET = 32'd125000000;
   localparam logic [WORD_W-1:0]  CLOCK_MARGIN_RESET = 32'd1000000;
   localparam logic [COUNT_W-1:0] LEVEL_COUNT_RESET  = 4'd8;

   // Reset values of the held quantities.
   localparam logic [WORD_W-1:0] FREQ_RESET  = 32'd1000;
   localparam logic [WORD_W-1:0] TWORD_RESET = 32'd34359;
   localparam logic [WORD_W-1:0] CLOCK_RESET = 32'd125000000;

   typedef enum logic [3:0] {
      CMD_ADJ_FREQ   = 4'd0,
      CMD_ADJ_TWORD  = 4'd1,
      CMD_ADJ_CLOCK  = 4'd2,
      CMD_FREQ_UP    = 4'd3,
      CMD_FREQ_DOWN  = 4'd4,
      CMD_TWORD_UP   = 4'd5,
      CMD_TWORD_DOWN = 4'd6,
      CMD_CLOCK_UP   = 4'd7,
      CMD_CLOCK_DOWN = 4'd8
   } dtwa_cmd_type;

   typedef enum logic [2:0] {
      REG_MAX_FREQ     = 3'd0,
      REG_MAX_TWORD    = 3'd1,
      REG_CLOCK_CENTER = 3'd2,
      REG_CLOCK_MARGIN = 3'd3,
      REG_FREQ_LEVELS  = 3'd4,
      REG_TWORD_LEVELS = 3'd5,
      REG_CLOCK_LEVELS = 3'd6
   } dtwa_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SUM,
      ST_APPLY,
      ST_CALC,
      ST_WAIT_DIV,
      ST_WAIT_MUL,
      ST_FINISH
   } dtwa_state_type;

   typedef struct packed {
      logic [WORD_W-1:0]  max_freq;
      logic [WORD_W-1:0]  max_tword;
      logic [WORD_W-1:0]  clock_center;
      logic [WORD_W-1:0]  clock_margin;
      logic [COUNT_W-1:0] freq_levels;
      logic [COUNT_W-1:0] tword_levels;
      logic [COUNT_W-1:0] clock_levels;
   } dtwa_cfg_type;

   // Decade step sizes; a 3-bit index reaches ten million at most.
   function automatic logic [STEP_W-1:0] step_size(input logic [LEVEL_W-1:0] idx);
      logic [STEP_W-1:0] s;
      case (idx)
         3'd0:    s = 24'd1;
         3'd1:    s = 24'd10;
         3'd2:    s = 24'd100;
         3'd3:    s = 24'd1000;
         3'd4:    s = 24'd10000;
         3'd5:    s = 24'd100000;
         3'd6:    s = 24'd1000000;
         3'd7:    s = 24'd10000000;
         default: s = 24'd1;
      endcase
      return s;
   endfunction

endpackage

@@ hw/rtl/dtwa_csr.sv @@
// Configuration register file with an APB-style access port.
module dtwa_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output dtwa_pkg::dtwa_cfg_type cfg
);
   import dtwa_pkg::*;

   dtwa_cfg_type cfg_ff;
   dtwa_cfg_type cfg_in;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAX_FREQ:     cfg_in.max_freq     = pwdata;
            REG_MAX_TWORD:    cfg_in.max_tword    = pwdata;
            REG_CLOCK_CENTER: cfg_in.clock_center = pwdata;
            REG_CLOCK_MARGIN: cfg_in.clock_margin = pwdata;
            REG_FREQ_LEVELS:  cfg_in.freq_levels  = pwdata[COUNT_W-1:0];
            REG_TWORD_LEVELS: cfg_in.tword_levels = pwdata[COUNT_W-1:0];
            REG_CLOCK_LEVELS: cfg_in.clock_levels = pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAX_FREQ:     prdata = cfg_ff.max_freq;
         REG_MAX_TWORD:    prdata = cfg_ff.max_tword;
         REG_CLOCK_CENTER: prdata = cfg_ff.clock_center;
         REG_CLOCK_MARGIN: prdata = cfg_ff.clock_margin;
         REG_FREQ_LEVELS:  prdata = {28'd0, cfg_ff.freq_levels};
         REG_TWORD_LEVELS: prdata = {28'd0, cfg_ff.tword_levels};
         REG_CLOCK_LEVELS: prdata = {28'd0, cfg_ff.clock_levels};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_freq     <= MAX_FREQ_RESET;
         cfg_ff.max_tword    <= MAX_TWORD_RESET;
         cfg_ff.clock_center <= CLOCK_CENTER_RESET;
         cfg_ff.clock_margin <= CLOCK_MARGIN_RESET;
         cfg_ff.freq_levels  <= LEVEL_COUNT_RESET;
         cfg_ff.tword_levels <= LEVEL_COUNT_RESET;
         cfg_ff.clock_levels <= LEVEL_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/dtwa_div.sv @@
// Bit-serial restoring divider: low 32 bits of (dividend << 32) / divisor.
module dtwa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import dtwa_pkg::*;

   localparam int DIV_STEPS = 2 * WORD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] num_ff, num_in;
   logic [WORD_W-1:0] quot_ff, quot_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W:0]   diff;
   logic              fits;

   assign done     = done_ff;
   assign quotient = quot_ff;

   // One quotient bit per cycle; the dividend's low word is all zeros.
   assign trial = {rem_ff, num_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         num_in   = dividend;
         dvs_in   = (divisor == '0) ? WORD_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         num_in   = {num_ff[WORD_W-2:0], 1'b0};
         quot_in  = {quot_ff[WORD_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

endmodule

@@ hw/rtl/dtwa_mul.sv @@
// Bit-serial shift-add multiplier returning the upper word of a 32 by 32 product.
module dtwa_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] multiplicand,
   input  logic [31:0] multiplier,
   output logic        done,
   output logic [31:0] product_hi
);
   import dtwa_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] mpl_ff, mpl_in;
   logic [WORD_W-1:0] mcd_ff, mcd_in;
   logic [WORD_W:0]   acc;

   assign done       = done_ff;
   assign product_hi = hi_ff;

   // The low product bits shift out and never feed back into the upper word.
   assign acc = {1'b0, hi_ff} + (mpl_ff[0] ? {1'b0, mcd_ff} : '0);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      hi_in    = hi_ff;
      mpl_in   = mpl_ff;
      mcd_in   = mcd_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         hi_in    = '0;
         mpl_in   = multiplier;
         mcd_in   = multiplicand;
      end else if (busy_ff) begin
         hi_in    = acc[WORD_W:1];
         mpl_in   = {1'b0, mpl_ff[WORD_W-1:1]};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      hi_ff  <= hi_in;
      mpl_ff <= mpl_in;
      mcd_ff <= mcd_in;
   end

endmodule

@@ hw/rtl/dds_tuning_word_adjuster.sv @@
// Top level of the DDS tuning word adjuster: command sequencer, held values and result register.
//
// This block keeps a DDS output frequency, its 32-bit tuning word and the reference clock,
// each with a decade step-size index, and turns knob requests into updated values. A request
// carries a command (adjust frequency, tuning word or clock by step_count steps, or move one
// step index up or down) and every request returns exactly one response with all six current
// values. Moves that would leave their bounds are dropped, but a response is still returned.
// A frequency or clock adjust recomputes the tuning word as (frequency << 32) / clock with a
// bit-serial restoring divider, one quotient bit per cycle. A tuning word adjust recomputes
// the frequency as the upper word of tuning_word * clock with a bit-serial multiplier. Level
// commands and unused codes go straight from decode to the finishing step. The sequencer
// works on one request at a time; the response sits in its own output register, so a new
// request is accepted while the previous response still waits for rsp_ready.
// Configuration registers are written through the APB-style port at byte address 4*index
// and should only be changed while no request is in flight.
module dds_tuning_word_adjuster (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_cmd,
   input  logic signed [7:0]  req_step_count,
   // Response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_frequency,
   output logic [31:0]        rsp_tuning_word,
   output logic [31:0]        rsp_ref_clock,
   output logic [2:0]         rsp_freq_level,
   output logic [2:0]         rsp_tword_level,
   output logic [2:0]         rsp_clock_level,
   // Configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import dtwa_pkg::*;

   localparam int SUM_W   = WORD_W + 3;
   localparam int DELTA_W = WORD_W + 1;

   dtwa_cfg_type   cfg;

   dtwa_state_type state_ff, state_in;
   logic [3:0]            cmd_ff, cmd_in;
   logic signed [7:0]     steps_ff, steps_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SUM_W-1:0]   bound_ff, bound_in;

   logic [WORD_W-1:0]  freq_ff, freq_in;
   logic [WORD_W-1:0]  tword_ff, tword_in;
   logic [WORD_W-1:0]  clock_ff, clock_in;
   logic [LEVEL_W-1:0] freq_idx_ff, freq_idx_in;
   logic [LEVEL_W-1:0] tword_idx_ff, tword_idx_in;
   logic [LEVEL_W-1:0] clock_idx_ff, clock_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_freq_ff, rsp_freq_in;
   logic [WORD_W-1:0]  rsp_tword_ff, rsp_tword_in;
   logic [WORD_W-1:0]  rsp_clock_ff, rsp_clock_in;
   logic [LEVEL_W-1:0] rsp_fidx_ff, rsp_fidx_in;
   logic [LEVEL_W-1:0] rsp_tidx_ff, rsp_tidx_in;
   logic [LEVEL_W-1:0] rsp_cidx_ff, rsp_cidx_in;

   logic                    div_start, div_done;
   logic [WORD_W-1:0]       div_quot;
   logic                    mul_start, mul_done;
   logic [WORD_W-1:0]       mul_hi;

   logic [LEVEL_W-1:0]      sel_idx;
   logic signed [STEP_W:0]  step_s;
   logic signed [DELTA_W-1:0] delta_prod;
   logic [WORD_W-1:0]       sel_value;
   logic signed [SUM_W-1:0] clock_lo_raw;
   logic signed [SUM_W-1:0] clock_lo;
   logic signed [SUM_W-1:0] clock_hi;
   logic signed [SUM_W-1:0] lo_sel;
   logic signed [SUM_W-1:0] hi_sel;
   logic                    in_bounds;
   logic                    slot_free;

   // A level count is clamped to one at the bottom and to the usable table size at the top.
   function automatic logic [COUNT_W-1:0] usable_levels(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] n;
      n = count;
      if (n < COUNT_W'(1)) n = COUNT_W'(1);
      if (n > COUNT_W'(LEVEL_LIMIT)) n = COUNT_W'(LEVEL_LIMIT);
      return n;
   endfunction

   function automatic logic [LEVEL_W-1:0] level_up(input logic [LEVEL_W-1:0] idx,
                                                   input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] n;
      logic [COUNT_W-1:0] nxt;
      n   = usable_levels(count);
      nxt = {1'b0, idx} + COUNT_W'(1);
      return (nxt >= n) ? LEVEL_W'(n - COUNT_W'(1)) : nxt[LEVEL_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] level_down(input logic [LEVEL_W-1:0] idx);
      return (idx == '0) ? '0 : idx - LEVEL_W'(1);
   endfunction

   dtwa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (freq_ff),
      .divisor  (clock_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   dtwa_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (tword_ff),
      .multiplier   (clock_ff),
      .done         (mul_done),
      .product_hi   (mul_hi)
   );

   // Datapath helpers for the adjust commands.
   always_comb begin
      case (cmd_ff)
         CMD_ADJ_FREQ: begin
            sel_idx   = freq_idx_ff;
            sel_value = freq_ff;
         end
         CMD_ADJ_TWORD: begin
            sel_idx   = tword_idx_ff;
            sel_value = tword_ff;
         end
         default: begin
            sel_idx   = clock_idx_ff;
            sel_value = clock_ff;
         end
      endcase
   end

   assign step_s     = $signed({1'b0, step_size(sel_idx)});
   assign delta_prod = DELTA_W'(step_s) * DELTA_W'(steps_ff);

   // Clock bounds are formed wide so that the window never wraps.
   assign clock_lo_raw = $signed({3'b000, cfg.clock_center}) - $signed({3'b000, cfg.clock_margin});
   assign clock_lo     = (clock_lo_raw < SUM_W'(1)) ? SUM_W'(1) : clock_lo_raw;
   assign clock_hi     = $signed({3'b000, cfg.clock_center}) + $signed({3'b000, cfg.clock_margin});

   always_comb begin
      case (cmd_ff)
         CMD_ADJ_FREQ: begin
            lo_sel = '0;
            hi_sel = $signed({3'b000, cfg.max_freq});
         end
         CMD_ADJ_TWORD: begin
            lo_sel = '0;
            hi_sel = $signed({3'b000, cfg.max_tword});
         end
         default: begin
            lo_sel = clock_lo;
            hi_sel = clock_hi;
         end
      endcase
   end

   // A downward move is checked against the lower bound, any other against the upper one.
   assign in_bounds = delta_ff[DELTA_W-1] ? (sum_ff >= bound_ff) : (sum_ff <= bound_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frequency   = rsp_freq_ff;
   assign rsp_tuning_word = rsp_tword_ff;
   assign rsp_ref_clock   = rsp_clock_ff;
   assign rsp_freq_level  = rsp_fidx_ff;
   assign rsp_tword_level = rsp_tidx_ff;
   assign rsp_clock_level = rsp_cidx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, sequencer outputs and next values of the held quantities.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      steps_in     = steps_ff;
      delta_in     = delta_ff;
      sum_in       = sum_ff;
      bound_in     = bound_ff;
      freq_in      = freq_ff;
      tword_in     = tword_ff;
      clock_in     = clock_ff;
      freq_idx_in  = freq_idx_ff;
      tword_idx_in = tword_idx_ff;
      clock_idx_in = clock_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_freq_in  = rsp_freq_ff;
      rsp_tword_in = rsp_tword_ff;
      rsp_clock_in = rsp_clock_ff;
      rsp_fidx_in  = rsp_fidx_ff;
      rsp_tidx_in  = rsp_tidx_ff;
      rsp_cidx_in  = rsp_cidx_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               steps_in = req_step_count;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            delta_in = delta_prod;
            state_in = ST_FINISH;
            case (cmd_ff)
               CMD_ADJ_FREQ, CMD_ADJ_TWORD, CMD_ADJ_CLOCK: state_in = ST_SUM;
               CMD_FREQ_UP:    freq_idx_in  = level_up(freq_idx_ff, cfg.freq_levels);
               CMD_FREQ_DOWN:  freq_idx_in  = level_down(freq_idx_ff);
               CMD_TWORD_UP:   tword_idx_in = level_up(tword_idx_ff, cfg.tword_levels);
               CMD_TWORD_DOWN: tword_idx_in = level_down(tword_idx_ff);
               CMD_CLOCK_UP:   clock_idx_in = level_up(clock_idx_ff, cfg.clock_levels);
               CMD_CLOCK_DOWN: clock_idx_in = level_down(clock_idx_ff);
               default: ;
            endcase
         end
         ST_SUM: begin
            sum_in   = $signed({3'b000, sel_value}) + SUM_W'(delta_ff);
            bound_in = delta_ff[DELTA_W-1] ? lo_sel : hi_sel;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_CALC;
            if (in_bounds) begin
               case (cmd_ff)
                  CMD_ADJ_FREQ:  freq_in  = sum_ff[WORD_W-1:0];
                  CMD_ADJ_TWORD: tword_in = sum_ff[WORD_W-1:0];
                  default: begin
                     clock_in = (sum_ff[WORD_W-1:0] == '0) ? WORD_W'(1) : sum_ff[WORD_W-1:0];
                  end
               endcase
            end
         end
         ST_CALC: begin
            if (cmd_ff == CMD_ADJ_TWORD) begin
               mul_start = 1'b1;
               state_in  = ST_WAIT_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT_DIV;
            end
         end
         ST_WAIT_DIV: begin
            if (div_done) begin
               tword_in = div_quot;
               state_in = ST_FINISH;
            end
         end
         ST_WAIT_MUL: begin
            if (mul_done) begin
               freq_in  = mul_hi;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The response waits here until the output register can take it.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = freq_ff;
               rsp_tword_in = tword_ff;
               rsp_clock_in = clock_ff;
               rsp_fidx_in  = freq_idx_ff;
               rsp_tidx_in  = tword_idx_ff;
               rsp_cidx_in  = clock_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= FREQ_RESET;
         tword_ff     <= TWORD_RESET;
         clock_ff     <= CLOCK_RESET;
         freq_idx_ff  <= '0;
         tword_idx_ff <= '0;
         clock_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         tword_ff     <= tword_in;
         clock_ff     <= clock_in;
         freq_idx_ff  <= freq_idx_in;
         tword_idx_ff <= tword_idx_in;
         clock_idx_ff <= clock_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      steps_ff     <= steps_in;
      delta_ff     <= delta_in;
      sum_ff       <= sum_in;
      bound_ff     <= bound_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_tword_ff <= rsp_tword_in;
      rsp_clock_ff <= rsp_clock_in;
      rsp_fidx_ff  <= rsp_fidx_in;
      rsp_tidx_ff  <= rsp_tidx_in;
      rsp_cidx_ff  <= rsp_cidx_in;
   end

`ifndef SYNTHESIS
   // The divider and multiplier only finish while the sequencer waits for them.
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_WAIT_DIV)
      else $error("divider finished outside its wait state");
   assert property (@(posedge clock) disable iff (reset) mul_done |-> state_ff == ST_WAIT_MUL)
      else $error("multiplier finished outside its wait state");
   // A new response is only ever loaded from the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FINISH && !(rsp_valid_ff && !rsp_ready)) |=> !rsp_valid_ff)
      else $error("response appeared without a finished request");
   // The reference clock never reaches zero, so the divider never sees a zero divisor.
   assert property (@(posedge clock) disable iff (reset) clock_ff != '0)
      else $error("reference clock reached zero");
`endif

endmodule
